// ----- hw/rtl/aes256_pkg.sv -----
package aes256_pkg;

  localparam int NUM_ROUNDS_DEF = 14;
  localparam int QUEUE_DEPTH = 2;

  typedef enum logic [1:0] {
    MODE_ECB_ENC = 2'd0,
    MODE_ECB_DEC = 2'd1,
    MODE_CTR     = 2'd2,
    MODE_CTR_ALT = 2'd3
  } mode_t;

  // configuration register indexes
  localparam logic [2:0] REG_KEY_0 = 3'd0;
  localparam logic [2:0] REG_KEY_1 = 3'd1;
  localparam logic [2:0] REG_KEY_2 = 3'd2;
  localparam logic [2:0] REG_KEY_3 = 3'd3;
  localparam logic [2:0] REG_IV_HI = 3'd4;
  localparam logic [2:0] REG_IV_LO = 3'd5;
  localparam logic [2:0] REG_MODE  = 3'd6;

  // classified job handed from front to back
  typedef struct packed {
    logic         decrypt;
    logic [127:0] block;
    logic [127:0] mask_data;
    logic [15:0]  keep;
    logic         ctr;
  } job_t;

  localparam logic [7:0] SBOX [256] = '{
    8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
    8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
    8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
    8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
    8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
    8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
    8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
    8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
    8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
    8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
    8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
    8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
    8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
    8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
    8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
    8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16};

  function automatic logic [7:0] inv_sub_byte(input logic [7:0] v);
    logic [7:0] r;
    r = 8'h00;
    for (int i = 0; i < 256; i++) begin
      if (SBOX[i] == v) r = 8'(i);
    end
    return r;
  endfunction

  function automatic logic [7:0] xt(input logic [7:0] a);
    return {a[6:0], 1'b0} ^ (a[7] ? 8'h1b : 8'h00);
  endfunction

  function automatic logic [31:0] sub_word(input logic [31:0] w);
    return {SBOX[w[31:24]], SBOX[w[23:16]], SBOX[w[15:8]], SBOX[w[7:0]]};
  endfunction

endpackage

// ----- hw/rtl/aes256_keysched.sv -----
// Key expansion: one 32-bit word per cycle into a 64-bit round key memory.
module aes256_keysched #(
  parameter int NUM_ROUNDS = aes256_pkg::NUM_ROUNDS_DEF,
  localparam int RK_WORDS = 2 * (NUM_ROUNDS + 1),
  localparam int KW = 4 * (NUM_ROUNDS + 1),
  localparam int RA_W = $clog2(RK_WORDS),
  localparam int WI_W = $clog2(KW + 1)
) (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            start,
  input  logic [255:0]    key,
  input  logic [RA_W-1:0] rd_addr,
  output logic [63:0]     rd_data,
  output logic            busy
);

  logic [63:0]     mem [RK_WORDS];
  logic [31:0]     win_r [8];
  logic [31:0]     win_nxt [8];
  logic [WI_W-1:0] idx_r, idx_nxt;
  logic            busy_r, busy_nxt;
  logic [31:0]     hold_r;
  logic [7:0]      rcon_r, rcon_nxt;
  logic [31:0]     t, w_new;
  logic            pend_r;

  // a pending restart already counts as busy
  assign busy = busy_r | pend_r | start;

  always_comb begin
    t = win_r[7];
    if (idx_r[2:0] == 3'd0) begin
      t = aes256_pkg::sub_word({win_r[7][23:0], win_r[7][31:24]}) ^ {rcon_r, 24'h0};
    end else if (idx_r[2:0] == 3'd4) begin
      t = aes256_pkg::sub_word(win_r[7]);
    end
    w_new = win_r[0] ^ t;
  end

  always_comb begin
    for (int i = 0; i < 8; i++) win_nxt[i] = win_r[i];
    idx_nxt  = idx_r;
    busy_nxt = busy_r;
    rcon_nxt = rcon_r;
    if (start || pend_r) begin
      for (int i = 0; i < 8; i++) win_nxt[i] = key[255-32*i -: 32];
      idx_nxt  = WI_W'(0);
      busy_nxt = 1'b1;
      rcon_nxt = 8'h01;
    end else if (busy_r) begin
      if (idx_r >= WI_W'(8)) begin
        for (int i = 0; i < 7; i++) win_nxt[i] = win_r[i+1];
        win_nxt[7] = w_new;
        if (idx_r[2:0] == 3'd0) rcon_nxt = aes256_pkg::xt(rcon_r);
      end
      idx_nxt = idx_r + WI_W'(1);
      if (idx_r == WI_W'(KW - 1)) busy_nxt = 1'b0;
    end
  end

  // words 0..7 come straight from the key, later ones from the recurrence
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      pend_r <= 1'b1;
      idx_r  <= '0;
      rcon_r <= 8'h01;
    end else begin
      busy_r <= busy_nxt;
      pend_r <= 1'b0;
      idx_r  <= idx_nxt;
      rcon_r <= rcon_nxt;
    end
    for (int i = 0; i < 8; i++) win_r[i] <= win_nxt[i];
  end

  logic [31:0] cur_word;
  assign cur_word = (idx_r < WI_W'(8)) ? key[255-32*idx_r[2:0] -: 32] : w_new;

  always_ff @(posedge clk) begin
    if (busy_r && !start && !pend_r) begin
      if (idx_r[0]) mem[RA_W'(idx_r >> 1)] <= {hold_r, cur_word};
      else hold_r <= cur_word;
    end
    rd_data <= mem[rd_addr];
  end

endmodule

// ----- hw/rtl/aes256_front.sv -----
// Front end: counter handling, job classification, and the job queue.
module aes256_front (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  logic [63:0]        in_data_hi,
  input  logic [63:0]        in_data_lo,
  input  logic [4:0]         in_byte_count,
  input  logic               in_message_start,
  input  logic [1:0]         mode,
  input  logic [127:0]       iv,
  output logic               job_valid,
  input  logic               job_take,
  output aes256_pkg::job_t   job
);

  localparam int QD = aes256_pkg::QUEUE_DEPTH;
  localparam int QA = $clog2(QD);

  aes256_pkg::job_t q_r [QD];
  logic [QA-1:0]    wp_r, rp_r;
  logic [QA:0]      cnt_r;
  logic [127:0]     ctr_r, ctr_nxt, ctr_use;
  aes256_pkg::job_t nj;
  logic             acc;
  logic [4:0]       n;

  assign in_stall  = (cnt_r == (QA+1)'(QD));
  assign acc       = in_valid && !in_stall;
  assign job_valid = (cnt_r != '0);
  assign job       = q_r[rp_r];

  // classify the incoming item
  always_comb begin
    n = (in_byte_count > 5'd16) ? 5'd16 : in_byte_count;
    ctr_use = (in_message_start) ? iv : ctr_r;
    nj.ctr = mode[1];
    nj.decrypt = (aes256_pkg::mode_t'(mode) == aes256_pkg::MODE_ECB_DEC);
    nj.mask_data = {in_data_hi, in_data_lo};
    nj.block = mode[1] ? ctr_use : {in_data_hi, in_data_lo};
    for (int i = 0; i < 16; i++) nj.keep[15-i] = !mode[1] || (5'(i) < n);
    ctr_nxt = ctr_r;
    if (mode[1]) ctr_nxt = ctr_use + 128'd1;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
      ctr_r <= '0;
    end else begin
      if (acc) begin
        wp_r  <= QA'(wp_r + QA'(1));
        ctr_r <= ctr_nxt;
      end
      if (job_take) rp_r <= QA'(rp_r + QA'(1));
      cnt_r <= cnt_r + (QA+1)'(acc) - (QA+1)'(job_take);
    end
    if (acc) q_r[wp_r] <= nj;
  end

endmodule

// ----- hw/rtl/aes256_core.sv -----
// Back end: one AES round per LOAD/RUN pair; key address issued the cycle before use.
module aes256_core #(
  parameter int NUM_ROUNDS = aes256_pkg::NUM_ROUNDS_DEF,
  localparam int RK_WORDS = 2 * (NUM_ROUNDS + 1),
  localparam int RA_W = $clog2(RK_WORDS),
  localparam int RC_W = $clog2(NUM_ROUNDS + 2)
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             job_valid,
  output logic             job_take,
  input  aes256_pkg::job_t job,
  input  logic             keys_busy,
  output logic [RA_W-1:0]  rk_addr,
  input  logic [63:0]      rk_data,
  output logic             out_valid,
  input  logic             out_stall,
  output logic [63:0]      out_result_hi,
  output logic [63:0]      out_result_lo
);

  typedef enum logic [1:0] {S_IDLE, S_LOAD, S_RUN} state_t;

  state_t           state_r;
  logic [RC_W-1:0]  rnd_r;
  logic [127:0]     s_r, rk_hi_part;
  logic [63:0]      rk_hold_r;
  aes256_pkg::job_t j_r;
  logic [127:0]     rk, s_nxt, res;
  logic             ov_r;
  logic [127:0]     out_r;
  logic             fire;

  assign out_valid     = ov_r;
  assign out_result_hi = out_r[127:64];
  assign out_result_lo = out_r[63:0];
  assign job_take      = (state_r == S_IDLE) && job_valid && !keys_busy;
  assign rk            = {rk_hold_r, rk_data};
  assign rk_hi_part    = '0;
  assign fire          = (state_r == S_RUN) && (rnd_r == RC_W'(NUM_ROUNDS)) &&
                         (!ov_r || !out_stall);

  // key address for the next cycle: high word ahead of LOAD, low word ahead of RUN
  logic [RC_W-1:0] key_rnd, rnd_sel;
  logic            rk_lo;
  always_comb begin
    rnd_sel = rnd_r;
    rk_lo   = 1'b1;
    if (state_r == S_RUN && rnd_r != RC_W'(NUM_ROUNDS)) begin
      rnd_sel = rnd_r + RC_W'(1);
      rk_lo   = 1'b0;
    end
    key_rnd = j_r.decrypt ? RC_W'(NUM_ROUNDS) - rnd_sel : rnd_sel;
    if (state_r == S_IDLE) begin
      key_rnd = job.decrypt ? RC_W'(NUM_ROUNDS) : '0;
      rk_lo   = 1'b0;
    end
    rk_addr = RA_W'({key_rnd, rk_lo});
  end

  function automatic logic [127:0] enc_round(input logic [127:0] s, input logic last);
    logic [7:0] b [16];
    logic [7:0] t [16];
    logic [127:0] o;
    for (int i = 0; i < 16; i++) b[i] = aes256_pkg::SBOX[s[127-8*i -: 8]];
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[i+4*c] = b[i+4*((c+i)&3)];
    for (int c = 0; c < 4; c++) begin
      if (last) begin
        for (int i = 0; i < 4; i++) o[127-8*(4*c+i) -: 8] = t[4*c+i];
      end else begin
        o[127-32*c -: 8]  = aes256_pkg::xt(t[4*c]) ^ aes256_pkg::xt(t[4*c+1]) ^ t[4*c+1]
                            ^ t[4*c+2] ^ t[4*c+3];
        o[119-32*c -: 8]  = t[4*c] ^ aes256_pkg::xt(t[4*c+1]) ^ aes256_pkg::xt(t[4*c+2])
                            ^ t[4*c+2] ^ t[4*c+3];
        o[111-32*c -: 8]  = t[4*c] ^ t[4*c+1] ^ aes256_pkg::xt(t[4*c+2])
                            ^ aes256_pkg::xt(t[4*c+3]) ^ t[4*c+3];
        o[103-32*c -: 8]  = aes256_pkg::xt(t[4*c]) ^ t[4*c] ^ t[4*c+1] ^ t[4*c+2]
                            ^ aes256_pkg::xt(t[4*c+3]);
      end
    end
    return o;
  endfunction

  function automatic logic [7:0] gm(input logic [7:0] a, input logic [3:0] k);
    logic [7:0] x2, x4, x8, p;
    x2 = aes256_pkg::xt(a);
    x4 = aes256_pkg::xt(x2);
    x8 = aes256_pkg::xt(x4);
    p = (k[0] ? a : 8'h0) ^ (k[1] ? x2 : 8'h0) ^ (k[2] ? x4 : 8'h0) ^ (k[3] ? x8 : 8'h0);
    return p;
  endfunction

  // inverse shift, inverse sbox, key add, then inverse mix unless last
  function automatic logic [127:0] dec_round(input logic [127:0] s, input logic [127:0] k,
                                             input logic last);
    logic [7:0] t [16];
    logic [7:0] a [16];
    logic [127:0] o;
    for (int c = 0; c < 4; c++)
      for (int i = 0; i < 4; i++) t[i+4*((c+i)&3)] = s[127-8*(i+4*c) -: 8];
    for (int i = 0; i < 16; i++) a[i] = aes256_pkg::inv_sub_byte(t[i]) ^ k[127-8*i -: 8];
    for (int c = 0; c < 4; c++) begin
      if (last) begin
        for (int i = 0; i < 4; i++) o[127-8*(4*c+i) -: 8] = a[4*c+i];
      end else begin
        o[127-32*c -: 8] = gm(a[4*c],4'hE)^gm(a[4*c+1],4'hB)^gm(a[4*c+2],4'hD)^gm(a[4*c+3],4'h9);
        o[119-32*c -: 8] = gm(a[4*c],4'h9)^gm(a[4*c+1],4'hE)^gm(a[4*c+2],4'hB)^gm(a[4*c+3],4'hD);
        o[111-32*c -: 8] = gm(a[4*c],4'hD)^gm(a[4*c+1],4'h9)^gm(a[4*c+2],4'hE)^gm(a[4*c+3],4'hB);
        o[103-32*c -: 8] = gm(a[4*c],4'hB)^gm(a[4*c+1],4'hD)^gm(a[4*c+2],4'h9)^gm(a[4*c+3],4'hE);
      end
    end
    return o;
  endfunction

  always_comb begin
    if (rnd_r == '0) s_nxt = s_r ^ rk;
    else if (j_r.decrypt) s_nxt = dec_round(s_r, rk, rnd_r == RC_W'(NUM_ROUNDS));
    else s_nxt = enc_round(s_r, rnd_r == RC_W'(NUM_ROUNDS)) ^ rk;
    for (int i = 0; i < 16; i++)
      res[127-8*i -: 8] = !j_r.keep[15-i] ? 8'h00 :
                          (j_r.ctr ? s_nxt[127-8*i -: 8] ^ j_r.mask_data[127-8*i -: 8]
                                   : s_nxt[127-8*i -: 8]);
  end

  // two key reads per round: high word, then low word; round fires on low
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      ov_r    <= 1'b0;
      rnd_r   <= '0;
    end else begin
      if (fire) ov_r <= 1'b1;
      else if (!out_stall) ov_r <= 1'b0;
      unique case (state_r)
        S_IDLE: begin
          if (job_take) begin
            j_r     <= job;
            s_r     <= job.block;
            rnd_r   <= '0;
            state_r <= S_LOAD;
          end
        end
        S_LOAD: begin
          rk_hold_r <= rk_data;
          state_r   <= S_RUN;
        end
        S_RUN: begin
          if (rnd_r == RC_W'(NUM_ROUNDS)) begin
            if (fire) begin
              out_r   <= res | rk_hi_part;
              state_r <= S_IDLE;
            end
          end else begin
            s_r     <= s_nxt;
            rnd_r   <= rnd_r + RC_W'(1);
            state_r <= S_LOAD;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

endmodule

// ----- hw/rtl/aes256_block_cipher_ecb_ctr.sv -----
// AES-256 ECB/CTR engine. A block passes from the input transfer into the job queue,
// leaves the queue, then runs 15 rounds of two 64-bit round-key reads each.
// The round unit takes a new block only once the last one has left it, so the two
// key memory reads per round set the throughput. Reset (synchronous, rst_n low):
// registers clear; the key schedule of the zero key then runs, and no block enters
// the round unit while it does. Each key write reruns the expansion.
module aes256_block_cipher_ecb_ctr #(
  parameter int NUM_ROUNDS = aes256_pkg::NUM_ROUNDS_DEF
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [63:0] in_data_hi,
  input  logic [63:0] in_data_lo,
  input  logic [4:0]  in_byte_count,
  input  logic        in_message_start,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [63:0] out_result_hi,
  output logic [63:0] out_result_lo,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [5:0]  paddr,
  input  logic [63:0] pwdata,
  output logic [63:0] prdata,
  output logic        pready
);

  localparam int RA_W = $clog2(2 * (NUM_ROUNDS + 1));

  logic [63:0] key_r [4];
  logic [63:0] iv_hi_r, iv_lo_r;
  logic [1:0]  mode_r;
  logic        wr, key_wr;
  logic [2:0]  ridx;

  assign pready = 1'b1;
  assign wr     = psel && penable && pwrite;
  assign ridx   = paddr[5:3];
  assign key_wr = wr && (ridx <= aes256_pkg::REG_KEY_3);

  // register file
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < 4; i++) key_r[i] <= '0;
      iv_hi_r <= '0;
      iv_lo_r <= '0;
      mode_r  <= '0;
    end else if (wr) begin
      case (ridx)
        aes256_pkg::REG_KEY_0, aes256_pkg::REG_KEY_1,
        aes256_pkg::REG_KEY_2, aes256_pkg::REG_KEY_3: key_r[ridx[1:0]] <= pwdata;
        aes256_pkg::REG_IV_HI: iv_hi_r <= pwdata;
        aes256_pkg::REG_IV_LO: iv_lo_r <= pwdata;
        aes256_pkg::REG_MODE:  mode_r  <= pwdata[1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (ridx)
      aes256_pkg::REG_KEY_0, aes256_pkg::REG_KEY_1,
      aes256_pkg::REG_KEY_2, aes256_pkg::REG_KEY_3: prdata = key_r[ridx[1:0]];
      aes256_pkg::REG_IV_HI: prdata = iv_hi_r;
      aes256_pkg::REG_IV_LO: prdata = iv_lo_r;
      aes256_pkg::REG_MODE:  prdata = {62'h0, mode_r};
      default:               prdata = '0;
    endcase
  end

  // key change restarts expansion the cycle after the write lands
  logic key_wr_r;
  always_ff @(posedge clk) begin
    if (!rst_n) key_wr_r <= 1'b0;
    else key_wr_r <= key_wr;
  end

  logic [RA_W-1:0]  rk_addr;
  logic [63:0]      rk_data;
  logic             keys_busy;
  logic             job_valid, job_take;
  aes256_pkg::job_t job;

  aes256_keysched #(.NUM_ROUNDS(NUM_ROUNDS)) u_keys (
    .clk, .rst_n, .start(key_wr_r),
    .key({key_r[0], key_r[1], key_r[2], key_r[3]}),
    .rd_addr(rk_addr), .rd_data(rk_data), .busy(keys_busy)
  );

  aes256_front u_front (
    .clk, .rst_n, .in_valid, .in_stall, .in_data_hi, .in_data_lo, .in_byte_count,
    .in_message_start, .mode(mode_r), .iv({iv_hi_r, iv_lo_r}),
    .job_valid, .job_take, .job
  );

  aes256_core #(.NUM_ROUNDS(NUM_ROUNDS)) u_core (
    .clk, .rst_n, .job_valid, .job_take, .job, .keys_busy,
    .rk_addr, .rk_data, .out_valid, .out_stall, .out_result_hi, .out_result_lo
  );

`ifndef SYNTHESIS
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_result_hi) && $stable(out_result_lo))
    else $error("result changed while stalled");
  a_no_take_busy: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> !keys_busy)
    else $error("job started during key expansion");
  a_take_valid: assert property (@(posedge clk) disable iff (!rst_n)
    job_take |-> job_valid)
    else $error("job taken from empty queue");
`endif

endmodule
